// ===== src/stir_pkg.sv =====
// Shared types and constants for the strided tensor index remap block.
// No dependencies; every other file imports this package.
package stir_pkg;

    localparam int NUM_DIMS   = 4;
    localparam int INDEX_BITS = 32;
    localparam int STRIDE_BITS = 32;
    localparam int CFG_IDX_BITS = 4;
    localparam int DIM_STAGES = INDEX_BITS + 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_STRIDE_BASE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_STRIDE_BASE  = CFG_IDX_BITS'(NUM_DIMS);
    localparam logic [CFG_IDX_BITS-1:0] REG_END             = CFG_IDX_BITS'(2 * NUM_DIMS);

    typedef struct packed {
        logic [INDEX_BITS-1:0] element_index;
        logic                  is_last;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_BITS-1:0] source_index;
        logic                  last_out;
        logic                  stride_fault;
    } t_out_word;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    fault;
        logic [2*INDEX_BITS-1:0] acc;
        logic [INDEX_BITS-1:0]   prod;
        logic [INDEX_BITS-1:0]   src;
    } t_stage;

endpackage

// ===== src/strided_tensor_index_remap.sv =====
// Strided tensor index remap: top level with stride registers and the stage chain.
// Accepts one word per cycle while the chain is not stalled; the per-dimension divider retires one bit per stage.
// A stall on the result side while a result is valid holds the whole chain in place.
// Synchronous reset clears all valid bits and sets output strides to 1, input strides to 0.
// Depends on stir_pkg and stir_dim.
module strided_tensor_index_remap
    import stir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_in_word                i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out_word               o_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [STRIDE_BITS-1:0]  i_cfg_data
);

    logic [STRIDE_BITS-1:0] r_out_stride [NUM_DIMS];
    logic [STRIDE_BITS-1:0] r_in_stride  [NUM_DIMS];
    t_stage                 chain [NUM_DIMS+1];
    t_stage                 tail;
    logic                   en;
    logic                   any_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (!i_rst_n) begin
                r_out_stride[d] <= STRIDE_BITS'(1);
                r_in_stride[d]  <= '0;
            end else if (i_cfg_valid) begin
                if (i_cfg_index >= REG_OUT_STRIDE_BASE && i_cfg_index < REG_IN_STRIDE_BASE
                    && i_cfg_index - REG_OUT_STRIDE_BASE == CFG_IDX_BITS'(d)) begin
                    r_out_stride[d] <= i_cfg_data;
                end
                if (i_cfg_index >= REG_IN_STRIDE_BASE && i_cfg_index < REG_END
                    && i_cfg_index - REG_IN_STRIDE_BASE == CFG_IDX_BITS'(d)) begin
                    r_in_stride[d] <= i_cfg_data;
                end
            end
        end
    end

    always_comb begin
        any_zero = 1'b0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (r_out_stride[d] == '0) begin
                any_zero = 1'b1;
            end
        end
    end

    assign tail    = chain[NUM_DIMS];
    assign en      = !(tail.valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        chain[0].valid = i_valid;
        chain[0].last  = i_data.is_last;
        chain[0].fault = any_zero;
        chain[0].acc   = {{INDEX_BITS{1'b0}}, i_data.element_index};
        chain[0].prod  = '0;
        chain[0].src   = '0;
    end

    for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
        stir_dim u_dim (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (r_out_stride[d]),
            .i_mul   (r_in_stride[d]),
            .i_stage (chain[d]),
            .o_stage (chain[d+1])
        );
    end

    assign o_valid             = tail.valid;
    assign o_data.source_index = tail.fault ? '0 : tail.src;
    assign o_data.last_out     = tail.last;
    assign o_data.stride_fault = tail.fault;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.stride_fault |-> o_data.source_index == '0)
        else $error("fault word carries a nonzero source index");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("blocked result changed");

endmodule

// ===== src/stir_dim.sv =====
// One dimension of the remap pipeline: a bit-per-stage restoring divider,
// then a multiply stage and an accumulate stage. Depends on stir_pkg.
module stir_dim
    import stir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [STRIDE_BITS-1:0] i_div,
    input  logic [STRIDE_BITS-1:0] i_mul,
    input  t_stage                 i_stage,
    output t_stage                 o_stage
);

    t_stage r_st [DIM_STAGES];
    t_stage n_st [DIM_STAGES];

    always_comb begin
        logic [INDEX_BITS:0] trial;
        logic                ge;
        logic [INDEX_BITS:0] diff;
        t_stage              prev;
        for (int k = 0; k < DIM_STAGES; k++) begin
            prev = (k == 0) ? i_stage : r_st[k-1];
            n_st[k] = prev;
            if (k < INDEX_BITS) begin
                trial = {prev.acc[2*INDEX_BITS-1:INDEX_BITS], prev.acc[INDEX_BITS-1]};
                ge = trial >= {1'b0, i_div};
                diff = ge ? (trial - {1'b0, i_div}) : trial;
                n_st[k].acc = {diff[INDEX_BITS-1:0], prev.acc[INDEX_BITS-2:0], ge};
            end else if (k == INDEX_BITS) begin
                n_st[k].prod = INDEX_BITS'(prev.acc[INDEX_BITS-1:0] * i_mul);
            end else begin
                n_st[k].src = prev.src + prev.prod;
                n_st[k].acc = {{INDEX_BITS{1'b0}}, prev.acc[2*INDEX_BITS-1:INDEX_BITS]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIM_STAGES; k++) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_stage = r_st[DIM_STAGES-1];

endmodule
